// File: src/dcss_pkg.sv
// ----------------------------------------------------------------------------
// dcss_pkg: shared types and constants
// Register map codes, field widths and the control structs passed between
// the configuration block, the front end and the back end.
// ----------------------------------------------------------------------------
package dcss_pkg;

	localparam int CFG_AW    = 4;
	localparam int CFG_DW    = 32;
	localparam int SAMPLE_W  = 16;
	localparam int LEVEL_W   = 17;
	localparam int BIN_W     = 6;
	localparam int DECIM_W   = 5;
	localparam int TRIG_W    = 16;

	// register indexes (byte address / 4)
	localparam logic [1:0] REG_ENABLE  = 2'd0;
	localparam logic [1:0] REG_DECIM   = 2'd1;
	localparam logic [1:0] REG_TRIGGER = 2'd2;

	localparam logic [DECIM_W-1:0] DECIM_RST = 5'd3;
	localparam logic [TRIG_W-1:0]  TRIG_RST  = 16'd533;

	typedef struct packed {
		logic               en;
		logic [DECIM_W-1:0] decim;
		logic [TRIG_W-1:0]  trig;
	} cfg_t;

	// back end -> front end ring access control
	typedef struct packed {
		logic rd_en;
		logic done;
	} ring_ctl_t;

endpackage

// File: src/dcss_front.sv
// ----------------------------------------------------------------------------
// dcss_front: sample intake
// Decimates incoming sample pairs, writes them into the two sliding rings and
// raises a snapshot request after the programmed number of kept samples.
// ----------------------------------------------------------------------------
module dcss_front import dcss_pkg::*; #(
	parameter int FFT_LEN = 128
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cfg_t                        cfg,
	input  logic                        push,
	output logic                        full,
	input  logic signed [SAMPLE_W-1:0]  pre_sample,
	input  logic signed [SAMPLE_W-1:0]  post_sample,
	output logic                        snap_req,
	output logic [$clog2(FFT_LEN)-1:0]  snap_start,
	input  ring_ctl_t                   ring_ctl,
	input  logic [$clog2(FFT_LEN)-1:0]  rd_addr,
	output logic signed [SAMPLE_W-1:0]  rd_pre,
	output logic signed [SAMPLE_W-1:0]  rd_post
);

	localparam int AW = $clog2(FFT_LEN);

	logic [3:0]            dec_cnt_q;
	logic [AW-1:0]         pos_q;
	logic [TRIG_W-1:0]     snap_cnt_q;
	logic                  pending_q;
	logic [FFT_LEN-1:0]    vld_q;
	logic                  rd_vld_q;
	logic [2*SAMPLE_W-1:0] ring_mem [FFT_LEN];
	logic [2*SAMPLE_W-1:0] rd_data_q;

	logic                  accept;
	logic [DECIM_W-1:0]    dec_f;
	logic [DECIM_W-1:0]    dec_inc;
	logic                  keep;
	logic [TRIG_W-1:0]     lim;
	logic [TRIG_W:0]       snap_inc;
	logic                  fire;

	assign accept   = push && !pending_q;
	assign full     = pending_q;
	assign dec_f    = (cfg.decim == '0) ? DECIM_W'(1) :
		(cfg.decim > DECIM_W'(16)) ? DECIM_W'(16) : cfg.decim;
	assign dec_inc  = {1'b0, dec_cnt_q} + DECIM_W'(1);
	assign keep     = dec_inc >= dec_f;
	assign lim      = (cfg.trig == '0) ? TRIG_W'(1) : cfg.trig;
	assign snap_inc = {1'b0, snap_cnt_q} + (TRIG_W+1)'(1);
	assign fire     = snap_inc >= {1'b0, lim};

	assign snap_req   = pending_q;
	assign snap_start = pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_cnt_q  <= '0;
			pos_q      <= '0;
			snap_cnt_q <= '0;
			pending_q  <= 1'b0;
			vld_q      <= '0;
			rd_vld_q   <= 1'b0;
		end else begin
			if (accept) begin
				if (!cfg.en) begin
					vld_q      <= '0;
					snap_cnt_q <= '0;
				end else if (!keep) begin
					dec_cnt_q <= dec_inc[3:0];
				end else begin
					dec_cnt_q    <= '0;
					vld_q[pos_q] <= 1'b1;
					pos_q        <= pos_q + AW'(1);
					if (fire) begin
						snap_cnt_q <= '0;
						pending_q  <= 1'b1;
					end else begin
						snap_cnt_q <= snap_inc[TRIG_W-1:0];
					end
				end
			end
			if (ring_ctl.done) begin
				pending_q <= 1'b0;
			end
			if (ring_ctl.rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && cfg.en && keep) begin
			ring_mem[pos_q] <= {pre_sample, post_sample};
		end
		if (ring_ctl.rd_en) begin
			rd_data_q <= ring_mem[rd_addr];
		end
	end

	// entries never written since the last clear read as zero
	assign rd_pre  = rd_vld_q ? rd_data_q[2*SAMPLE_W-1:SAMPLE_W] : '0;
	assign rd_post = rd_vld_q ? rd_data_q[SAMPLE_W-1:0] : '0;

endmodule

// File: src/dcss_lvl.sv
// ----------------------------------------------------------------------------
// dcss_lvl: bin level unit
// Iterative magnitude and log2 of one complex bin, scaled to Q8.8 dB.
// ----------------------------------------------------------------------------
module dcss_lvl import dcss_pkg::*; #(
	parameter int FFT_LEN = 128,
	parameter int IN_W    = 35
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [IN_W-1:0]     re,
	input  logic signed [IN_W-1:0]     im,
	output logic                       done,
	output logic signed [LEVEL_W-1:0]  level
);

	localparam longint EPS_Q16 =
		(longint'(FFT_LEN) * 64'sd54975581389 + 64'sd500000000) / 64'sd1000000000;
	localparam int LOG_OFS = (39 + $clog2(FFT_LEN)) * 65536;
	localparam logic signed [27:0] DB_PER_OCT = 28'sd101008905;

	localparam logic [3:0] L_IDLE  = 4'd0;
	localparam logic [3:0] L_SQ    = 4'd1;
	localparam logic [3:0] L_SUM   = 4'd2;
	localparam logic [3:0] L_NORM  = 4'd3;
	localparam logic [3:0] L_SQRT  = 4'd4;
	localparam logic [3:0] L_VAL   = 4'd5;
	localparam logic [3:0] L_MSB   = 4'd6;
	localparam logic [3:0] L_MUL   = 4'd7;
	localparam logic [3:0] L_FIX   = 4'd8;
	localparam logic [3:0] L_SCALE = 4'd9;
	localparam logic [3:0] L_ROUND = 4'd10;

	function automatic logic [30:0] abs_cap(input logic signed [IN_W-1:0] v);
		logic [63:0] a;
		a = v[IN_W-1] ? 64'(-v) : 64'(v);
		if (a > 64'h7FFF_FFFF) begin
			a = 64'h7FFF_FFFF;
		end
		return a[30:0];
	endfunction

	logic [3:0]         state_q;
	logic               done_q;
	logic [30:0]        ar_q, ai_q;
	logic [61:0]        sqa_q, sqb_q;
	logic [62:0]        ns_q;
	logic [5:0]         sh_q;
	logic [62:0]        v_q, r_q, bit_q;
	logic [47:0]        nv_q;
	logic [5:0]         p_q;
	logic [30:0]        y_q;
	logic [61:0]        yy_q;
	logic [15:0]        frac_q;
	logic [3:0]         it_q;
	logic signed [50:0] prod_q;
	logic signed [LEVEL_W-1:0] level_q;

	logic [63:0]        rb;
	logic [31:0]        t;
	logic signed [22:0] diff;
	logic [50:0]        mag;
	logic [18:0]        q;
	logic signed [LEVEL_W-1:0] lv;

	assign rb   = {1'b0, r_q} + {1'b0, bit_q};
	assign t    = yy_q[61:30];
	assign diff = 23'({p_q, frac_q}) - 23'(LOG_OFS);
	assign mag  = prod_q[50] ? 51'(-prod_q) : 51'(prod_q);
	assign q    = 19'((mag + 51'(64'h8000_0000)) >> 32);

	always_comb begin
		if (prod_q[50]) begin
			lv = (q > 19'd51200) ? -LEVEL_W'(51200) : -LEVEL_W'(q);
		end else begin
			lv = (q > 19'd1600) ? LEVEL_W'(1600) : LEVEL_W'(q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				L_IDLE: begin
					if (start) begin
						ar_q    <= abs_cap(re);
						ai_q    <= abs_cap(im);
						state_q <= L_SQ;
					end
				end
				L_SQ: begin
					sqa_q   <= ar_q * ar_q;
					sqb_q   <= ai_q * ai_q;
					state_q <= L_SUM;
				end
				L_SUM: begin
					ns_q    <= {1'b0, sqa_q} + {1'b0, sqb_q};
					sh_q    <= '0;
					state_q <= L_NORM;
				end
				L_NORM: begin
					// even left shift until the square reaches 2^60, at most 32
					if (sh_q < 6'd32 && ns_q < (63'd1 << 60)) begin
						ns_q <= ns_q << 2;
						sh_q <= sh_q + 6'd2;
					end else begin
						v_q     <= ns_q;
						r_q     <= '0;
						bit_q   <= 63'd1 << 62;
						state_q <= L_SQRT;
					end
				end
				L_SQRT: begin
					if ({1'b0, v_q} >= rb) begin
						v_q <= v_q - rb[62:0];
						r_q <= (r_q >> 1) + bit_q;
					end else begin
						r_q <= r_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q[0]) begin
						state_q <= L_VAL;
					end
				end
				L_VAL: begin
					nv_q    <= (48'(r_q[31:0]) << ((6'd32 - sh_q) >> 1)) + 48'(EPS_Q16);
					p_q     <= 6'd47;
					state_q <= L_MSB;
				end
				L_MSB: begin
					if (nv_q[47]) begin
						y_q     <= nv_q[47:17];
						it_q    <= '0;
						frac_q  <= '0;
						state_q <= L_MUL;
					end else begin
						nv_q <= nv_q << 1;
						p_q  <= p_q - 6'd1;
					end
				end
				L_MUL: begin
					yy_q    <= y_q * y_q;
					state_q <= L_FIX;
				end
				L_FIX: begin
					y_q    <= t[31] ? t[31:1] : t[30:0];
					frac_q <= {frac_q[14:0], t[31]};
					it_q   <= it_q + 4'd1;
					state_q <= (it_q == 4'd15) ? L_SCALE : L_MUL;
				end
				L_SCALE: begin
					prod_q  <= diff * DB_PER_OCT;
					state_q <= L_ROUND;
				end
				L_ROUND: begin
					level_q <= lv;
					done_q  <= 1'b1;
					state_q <= L_IDLE;
				end
				default: begin
					state_q <= L_IDLE;
				end
			endcase
		end
	end

	assign done  = done_q;
	assign level = level_q;

endmodule

// File: src/dcss_back.sv
// ----------------------------------------------------------------------------
// dcss_back: snapshot engine
// Copies both rings through the Hann window, runs a direct DFT per bin with
// one MAC per component and channel, and hands each bin to the level units.
// ----------------------------------------------------------------------------
module dcss_back import dcss_pkg::*; #(
	parameter int FFT_LEN = 128
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        snap_req,
	input  logic [$clog2(FFT_LEN)-1:0]  snap_start,
	output ring_ctl_t                   ring_ctl,
	output logic [$clog2(FFT_LEN)-1:0]  rd_addr,
	input  logic signed [SAMPLE_W-1:0]  rd_pre,
	input  logic signed [SAMPLE_W-1:0]  rd_post,
	output logic                        empty,
	input  logic                        pop,
	output logic [BIN_W-1:0]            bin_number,
	output logic signed [LEVEL_W-1:0]   pre_level_db,
	output logic signed [LEVEL_W-1:0]   post_level_db,
	output logic                        last_bin
);

	localparam int AW      = $clog2(FFT_LEN);
	localparam int KW      = AW - 1;
	localparam int HALF    = FFT_LEN / 2;
	localparam int WORK_W  = 27;
	localparam int TW_W    = 32;
	localparam int TERM_W  = 28;
	localparam int ACC_W   = TERM_W + AW;
	localparam int CP_W    = SAMPLE_W + TW_W;
	localparam int DP_W    = WORK_W + TW_W;

	localparam longint ONE_Q30     = 64'sd1073741824;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint SIN_DIV [6] = '{156, 110, 72, 42, 20, 6};
	localparam longint COS_DIV [6] = '{132, 90, 56, 30, 12, 2};

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_COPY = 3'd1;
	localparam logic [2:0] ST_DFT  = 3'd2;
	localparam logic [2:0] ST_LVL  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	// Q30 cos or sin of a phase given in 2^-32 turns (table build only)
	function automatic longint trig_q30(input longint ph, input bit want_sin);
		longint qd, r, x, x2, ts, tc, sv, cv, res;
		qd = (ph >>> 30) & 64'sd3;
		r  = ph & 64'sh3FFF_FFFF;
		x  = r * HALF_PI_Q30 / ONE_Q30;
		x2 = x * x / ONE_Q30;
		ts = ONE_Q30;
		tc = ONE_Q30;
		for (int i = 0; i < 6; i++) begin
			ts = ONE_Q30 - (x2 * ts / ONE_Q30) / SIN_DIV[i];
			tc = ONE_Q30 - (x2 * tc / ONE_Q30) / COS_DIV[i];
		end
		sv = x * ts / ONE_Q30;
		cv = tc;
		case (qd)
			64'sd0:  res = want_sin ? sv : cv;
			64'sd1:  res = want_sin ? cv : -sv;
			64'sd2:  res = want_sin ? -sv : -cv;
			default: res = want_sin ? -cv : sv;
		endcase
		return res;
	endfunction

	logic signed [TW_W-1:0] tw_cos_tab [FFT_LEN];
	logic signed [TW_W-1:0] tw_sin_tab [FFT_LEN];
	logic signed [TW_W-1:0] win_tab    [FFT_LEN];

	for (genvar g = 0; g < FFT_LEN; g++) begin : g_tab
		localparam longint PH_T  = (longint'(g % FFT_LEN) << 32) / FFT_LEN;
		localparam longint PH_W  = (longint'(g % (FFT_LEN - 1)) << 32) / (FFT_LEN - 1);
		localparam longint COS_T = trig_q30(PH_T, 1'b0);
		localparam longint SIN_T = trig_q30(PH_T, 1'b1);
		localparam longint WIN   = (ONE_Q30 - trig_q30(PH_W, 1'b0)) / 2;
		assign tw_cos_tab[g] = TW_W'(COS_T);
		assign tw_sin_tab[g] = TW_W'(SIN_T);
		assign win_tab[g]    = TW_W'(WIN);
	end

	logic [2:0]    state_q;
	logic [AW:0]   cnt_q;
	logic [KW-1:0] k_q;
	logic [AW-1:0] start_q;

	// window copy pipeline
	logic                     cp_v1_q, cp_v2_q;
	logic [AW-1:0]            cp_j1_q, cp_j2_q;
	logic signed [CP_W-1:0]   cprod_pre_s2, cprod_post_s2;
	logic signed [CP_W-1:0]   cw_pre, cw_post;
	logic signed [WORK_W-1:0] work_pre  [FFT_LEN];
	logic signed [WORK_W-1:0] work_post [FFT_LEN];

	// DFT pipeline
	logic                     dv1_q, dv2_q, dv3_q;
	logic [AW-1:0]            m_s1;
	logic [AW+KW-1:0]         jk;
	logic signed [WORK_W-1:0] wpre_s1, wpost_s1;
	logic signed [DP_W-1:0]   pc_pre_s2, ps_pre_s2, pc_post_s2, ps_post_s2;
	logic signed [DP_W-1:0]   rc_pre, rs_pre, rc_post, rs_post;
	logic signed [TERM_W-1:0] tc_pre_s3, ts_pre_s3, tc_post_s3, ts_post_s3;
	logic signed [ACC_W-1:0]  acc_re_pre_q, acc_im_pre_q, acc_re_post_q, acc_im_post_q;

	// level units and output register
	logic                      lvl_start_q;
	logic                      pre_done_q, post_done_q;
	logic                      pre_dn, post_dn;
	logic signed [LEVEL_W-1:0] pre_lvl, post_lvl;
	logic                      out_vld_q;
	logic [BIN_W-1:0]          bin_q;
	logic signed [LEVEL_W-1:0] pre_db_q, post_db_q;
	logic                      last_q;

	logic issue, copy_done, dft_done, lvl_both, load, last_k, acc_clr;

	assign issue     = (state_q == ST_COPY || state_q == ST_DFT) && !cnt_q[AW];
	assign copy_done = (state_q == ST_COPY) && cnt_q[AW] && !cp_v1_q && !cp_v2_q;
	assign dft_done  = (state_q == ST_DFT) && cnt_q[AW] && !dv1_q && !dv2_q && !dv3_q;
	assign lvl_both  = (pre_done_q || pre_dn) && (post_done_q || post_dn);
	assign load      = (state_q == ST_OUT) && (!out_vld_q || pop);
	assign last_k    = (k_q == KW'(HALF - 1));
	assign acc_clr   = copy_done || (load && !last_k);

	assign ring_ctl.rd_en = issue && (state_q == ST_COPY);
	assign ring_ctl.done  = copy_done;
	assign rd_addr        = start_q + cnt_q[AW-1:0];

	assign jk = cnt_q[AW-1:0] * k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			k_q         <= '0;
			start_q     <= '0;
			cp_v1_q     <= 1'b0;
			cp_v2_q     <= 1'b0;
			dv1_q       <= 1'b0;
			dv2_q       <= 1'b0;
			dv3_q       <= 1'b0;
			lvl_start_q <= 1'b0;
			pre_done_q  <= 1'b0;
			post_done_q <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			cp_v1_q     <= issue && (state_q == ST_COPY);
			cp_v2_q     <= cp_v1_q;
			dv1_q       <= issue && (state_q == ST_DFT);
			dv2_q       <= dv1_q;
			dv3_q       <= dv2_q;
			lvl_start_q <= 1'b0;
			if (issue) begin
				cnt_q <= cnt_q + (AW+1)'(1);
			end
			if (pop && out_vld_q) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (snap_req) begin
						start_q <= snap_start;
						cnt_q   <= '0;
						state_q <= ST_COPY;
					end
				end
				ST_COPY: begin
					if (copy_done) begin
						cnt_q   <= '0;
						k_q     <= '0;
						state_q <= ST_DFT;
					end
				end
				ST_DFT: begin
					if (dft_done) begin
						lvl_start_q <= 1'b1;
						pre_done_q  <= 1'b0;
						post_done_q <= 1'b0;
						state_q     <= ST_LVL;
					end
				end
				ST_LVL: begin
					if (pre_dn) begin
						pre_done_q <= 1'b1;
					end
					if (post_dn) begin
						post_done_q <= 1'b1;
					end
					if (lvl_both) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (load) begin
						out_vld_q <= 1'b1;
						if (last_k) begin
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + KW'(1);
							cnt_q   <= '0;
							state_q <= ST_DFT;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// truncation toward zero of the window and twiddle products
	assign cw_pre  = cprod_pre_s2 + (cprod_pre_s2[CP_W-1] ? CP_W'(20'hFFFFF) : '0);
	assign cw_post = cprod_post_s2 + (cprod_post_s2[CP_W-1] ? CP_W'(20'hFFFFF) : '0);
	assign rc_pre  = pc_pre_s2 + (pc_pre_s2[DP_W-1] ? DP_W'(30'h3FFF_FFFF) : '0);
	assign rs_pre  = ps_pre_s2 + (ps_pre_s2[DP_W-1] ? DP_W'(30'h3FFF_FFFF) : '0);
	assign rc_post = pc_post_s2 + (pc_post_s2[DP_W-1] ? DP_W'(30'h3FFF_FFFF) : '0);
	assign rs_post = ps_post_s2 + (ps_post_s2[DP_W-1] ? DP_W'(30'h3FFF_FFFF) : '0);

	always_ff @(posedge clk) begin
		// window stage
		cp_j1_q       <= cnt_q[AW-1:0];
		cp_j2_q       <= cp_j1_q;
		cprod_pre_s2  <= rd_pre * win_tab[cp_j1_q];
		cprod_post_s2 <= rd_post * win_tab[cp_j1_q];
		if (cp_v2_q) begin
			work_pre[cp_j2_q]  <= WORK_W'(cw_pre >>> 20);
			work_post[cp_j2_q] <= WORK_W'(cw_post >>> 20);
		end
		// DFT stages
		m_s1 <= jk[AW-1:0];
		if (issue && state_q == ST_DFT) begin
			wpre_s1  <= work_pre[cnt_q[AW-1:0]];
			wpost_s1 <= work_post[cnt_q[AW-1:0]];
		end
		pc_pre_s2  <= wpre_s1 * tw_cos_tab[m_s1];
		ps_pre_s2  <= wpre_s1 * tw_sin_tab[m_s1];
		pc_post_s2 <= wpost_s1 * tw_cos_tab[m_s1];
		ps_post_s2 <= wpost_s1 * tw_sin_tab[m_s1];
		tc_pre_s3  <= TERM_W'(rc_pre >>> 30);
		ts_pre_s3  <= TERM_W'(rs_pre >>> 30);
		tc_post_s3 <= TERM_W'(rc_post >>> 30);
		ts_post_s3 <= TERM_W'(rs_post >>> 30);
		if (acc_clr) begin
			acc_re_pre_q  <= '0;
			acc_im_pre_q  <= '0;
			acc_re_post_q <= '0;
			acc_im_post_q <= '0;
		end else if (dv3_q) begin
			acc_re_pre_q  <= acc_re_pre_q + ACC_W'(tc_pre_s3);
			acc_im_pre_q  <= acc_im_pre_q - ACC_W'(ts_pre_s3);
			acc_re_post_q <= acc_re_post_q + ACC_W'(tc_post_s3);
			acc_im_post_q <= acc_im_post_q - ACC_W'(ts_post_s3);
		end
		// result register
		if (load) begin
			bin_q     <= BIN_W'(k_q);
			pre_db_q  <= pre_lvl;
			post_db_q <= post_lvl;
			last_q    <= last_k;
		end
	end

	dcss_lvl #(
		.FFT_LEN (FFT_LEN),
		.IN_W    (ACC_W)
	) u_lvl_pre (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lvl_start_q),
		.re     (acc_re_pre_q),
		.im     (acc_im_pre_q),
		.done   (pre_dn),
		.level  (pre_lvl)
	);

	dcss_lvl #(
		.FFT_LEN (FFT_LEN),
		.IN_W    (ACC_W)
	) u_lvl_post (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lvl_start_q),
		.re     (acc_re_post_q),
		.im     (acc_im_post_q),
		.done   (post_dn),
		.level  (post_lvl)
	);

	assign empty         = !out_vld_q;
	assign bin_number    = bin_q;
	assign pre_level_db  = pre_db_q;
	assign post_level_db = post_db_q;
	assign last_bin      = last_q;

endmodule

// File: src/dual_channel_spectrum_snapshot.sv
// ----------------------------------------------------------------------------
// dual_channel_spectrum_snapshot: two-channel windowed log spectrum
// Decimating sample intake, snapshot DFT engine and APB register block.
// ----------------------------------------------------------------------------
// Usage:
//  - Input queue (push/full): one request carries a pre and a post sample.
//    A request is taken whenever full is low. One of every
//    decimation_factor requests is written to the rings (0 acts as 1, above
//    16 as 16); after trigger_interval kept samples a snapshot starts.
//  - On a snapshot, full stays high while the engine copies both rings through
//    the window; then intake runs again. A further snapshot waits (full) until
//    the engine has finished the previous one.
//  - Result queue (empty/pop): FFT_LEN/2 requests per snapshot, bin 0 first,
//    last_bin on the final one. Each bin passes through the DFT MACs and then
//    the level units (the square root iterates one step a cycle, the log2
//    squares and renormalizes once per fraction bit).
//  - A stalled result queue holds the engine; the output register keeps the
//    current bin until popped and nothing is dropped.
//  - Reset clears the counters, marks every ring entry as zero, and restores
//    enable=0, decimation 3, interval 533. Write registers only while idle.
// ----------------------------------------------------------------------------
module dual_channel_spectrum_snapshot import dcss_pkg::*; #(
	parameter int FFT_LEN = 128
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// input queue
	input  logic                       push,
	output logic                       full,
	input  logic signed [SAMPLE_W-1:0] pre_sample,
	input  logic signed [SAMPLE_W-1:0] post_sample,
	// result queue
	output logic                       empty,
	input  logic                       pop,
	output logic [BIN_W-1:0]           bin_number,
	output logic signed [LEVEL_W-1:0]  pre_level_db,
	output logic signed [LEVEL_W-1:0]  post_level_db,
	output logic                       last_bin,
	// APB register port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [CFG_AW-1:0]          paddr,
	input  logic [CFG_DW-1:0]          pwdata,
	output logic [CFG_DW-1:0]          prdata,
	output logic                       pready
);

	localparam int AW = $clog2(FFT_LEN);

	cfg_t          cfg_q;
	logic          wr_en;
	logic          snap_req;
	logic [AW-1:0] snap_start;
	ring_ctl_t     ring_ctl;
	logic [AW-1:0] rd_addr;
	logic signed [SAMPLE_W-1:0] rd_pre, rd_post;

	// register block: zero wait state, write in the access phase
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.en    <= 1'b0;
			cfg_q.decim <= DECIM_RST;
			cfg_q.trig  <= TRIG_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_ENABLE:  cfg_q.en    <= pwdata[0];
				REG_DECIM:   cfg_q.decim <= pwdata[DECIM_W-1:0];
				REG_TRIGGER: cfg_q.trig  <= pwdata[TRIG_W-1:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_ENABLE:  prdata = CFG_DW'(cfg_q.en);
			REG_DECIM:   prdata = CFG_DW'(cfg_q.decim);
			REG_TRIGGER: prdata = CFG_DW'(cfg_q.trig);
			default:     prdata = '0;
		endcase
	end

	// intake: decimation, rings, snapshot trigger
	dcss_front #(
		.FFT_LEN (FFT_LEN)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.push        (push),
		.full        (full),
		.pre_sample  (pre_sample),
		.post_sample (post_sample),
		.snap_req    (snap_req),
		.snap_start  (snap_start),
		.ring_ctl    (ring_ctl),
		.rd_addr     (rd_addr),
		.rd_pre      (rd_pre),
		.rd_post     (rd_post)
	);

	// snapshot engine: window copy, DFT, levels, result register
	dcss_back #(
		.FFT_LEN (FFT_LEN)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.snap_req      (snap_req),
		.snap_start    (snap_start),
		.ring_ctl      (ring_ctl),
		.rd_addr       (rd_addr),
		.rd_pre        (rd_pre),
		.rd_post       (rd_post),
		.empty         (empty),
		.pop           (pop),
		.bin_number    (bin_number),
		.pre_level_db  (pre_level_db),
		.post_level_db (post_level_db),
		.last_bin      (last_bin)
	);

endmodule
